// File: rtl/gpe_pkg.sv
package gpe_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_FG_COLOR   = 3'd0;
    localparam logic [2:0] REG_BG_COLOR   = 3'd1;
    localparam logic [2:0] REG_FILL_BG    = 3'd2;
    localparam logic [2:0] REG_ORIGIN_X   = 3'd3;
    localparam logic [2:0] REG_ORIGIN_Y   = 3'd4;

    // reset values of the configuration registers
    localparam logic [3:0] FG_COLOR_RST   = 4'd15;
    localparam logic [3:0] BG_COLOR_RST   = 4'd0;
    localparam logic       FILL_BG_RST    = 1'b0;
    localparam logic [9:0] ORIGIN_X_RST   = 10'd20;
    localparam logic [8:0] ORIGIN_Y_RST   = 9'd20;

    // input action codes
    localparam logic ACT_STORE  = 1'b0;
    localparam logic ACT_RENDER = 1'b1;

    typedef struct packed {
        logic [3:0] fg_color;
        logic [3:0] bg_color;
        logic       fill_background;
        logic [9:0] origin_x;
        logic [8:0] origin_y;
    } cfg_t;

    // one pixel write, without the last flag
    typedef struct packed {
        logic [10:0] pixel_x;
        logic [8:0]  pixel_y;
        logic [3:0]  pixel_color;
        logic [15:0] byte_offset;
        logic [7:0]  bit_mask;
    } pix_t;

    // sequencer to output stage
    typedef struct packed {
        logic step;
        logic emit;
        logic flush;
    } ctl_t;

endpackage

// File: rtl/gpe_in_if.sv
interface gpe_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] char_code;
    logic [6:0] char_pos;
    logic [2:0] font_row;
    logic [7:0] font_byte;

    modport source (output valid, output action, output char_code, output char_pos,
                    output font_row, output font_byte, input ready);
    modport sink   (input valid, input action, input char_code, input char_pos,
                    input font_row, input font_byte, output ready);
endinterface

// File: rtl/gpe_pix_if.sv
interface gpe_pix_if;
    logic        valid;
    logic        ready;
    logic [10:0] pixel_x;
    logic [8:0]  pixel_y;
    logic [3:0]  pixel_color;
    logic [15:0] byte_offset;
    logic [7:0]  bit_mask;
    logic        last_pixel;

    modport source (output valid, output pixel_x, output pixel_y, output pixel_color,
                    output byte_offset, output bit_mask, output last_pixel, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input pixel_color,
                    input byte_offset, input bit_mask, input last_pixel, output ready);
endinterface

// File: rtl/gpe_ram.sv
module gpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/gpe_seq.sv
module gpe_seq #(
    parameter int FONT_CHARS = 256,
    parameter int ROW_BYTES  = 80
) (
    input  logic          clk,
    input  logic          rst_n,
    gpe_in_if.sink        in_ch,
    input  gpe_pkg::cfg_t cfg,
    input  logic          free,
    output gpe_pkg::ctl_t ctl,
    output gpe_pkg::pix_t pix
);

    localparam int         AW = $clog2(FONT_CHARS * 8);
    localparam logic [8:0] FC = 9'(FONT_CHARS);
    localparam logic [7:0] RB = 8'(ROW_BYTES);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FIRST = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [2:0]  row_reg, row_next;
    logic [2:0]  col_reg, col_next;
    logic [7:0]  bits_reg, bits_next;
    logic [10:0] x_reg, x_next;
    logic [10:0] xb_reg, xb_next;
    logic [8:0]  y_reg, y_next;
    logic [15:0] row_off_reg, row_off_next;
    logic [7:0]  code_reg, code_next;
    logic        code_ok_reg, code_ok_next;

    logic          in_code_ok;
    logic          accept;
    logic          ram_we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [7:0]    rdata;

    // font store
    gpe_ram #(
        .WIDTH (8),
        .DEPTH (FONT_CHARS * 8)
    ) u_font (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (in_ch.font_byte),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign in_code_ok  = ({1'b0, in_ch.char_code} < FC);

    assign ram_we = accept && (in_ch.action == gpe_pkg::ACT_STORE) && in_code_ok;
    assign waddr  = AW'({in_ch.char_code, in_ch.font_row});

    // row 0 is read at the accept edge; during a row the next row is prefetched
    assign raddr = (state_reg == S_IDLE) ? AW'({in_ch.char_code, 3'd0})
                                         : AW'({code_reg, row_reg + 3'd1});

    // next state and datapath
    always_comb
    begin
        state_next   = state_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        bits_next    = bits_reg;
        x_next       = x_reg;
        xb_next      = xb_reg;
        y_next       = y_reg;
        row_off_next = row_off_reg;
        code_next    = code_reg;
        code_ok_next = code_ok_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (in_ch.action == gpe_pkg::ACT_RENDER))
                begin
                    code_next    = in_ch.char_code;
                    code_ok_next = in_code_ok;
                    xb_next      = {1'b0, cfg.origin_x} + {1'b0, in_ch.char_pos, 3'b000};
                    x_next       = {1'b0, cfg.origin_x} + {1'b0, in_ch.char_pos, 3'b000};
                    y_next       = cfg.origin_y;
                    row_off_next = {7'b0, cfg.origin_y} * {8'b0, RB};
                    row_next     = 3'd0;
                    state_next   = S_FIRST;
                end
            end
            S_FIRST:
            begin
                bits_next  = code_ok_reg ? rdata : 8'h00;
                col_next   = 3'd0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (free)
                begin
                    if (col_reg == 3'd7)
                    begin
                        if (row_reg == 3'd7)
                        begin
                            state_next = S_FLUSH;
                        end
                        else
                        begin
                            row_next     = row_reg + 3'd1;
                            col_next     = 3'd0;
                            bits_next    = code_ok_reg ? rdata : 8'h00;
                            x_next       = xb_reg;
                            y_next       = y_reg + 9'd1;
                            row_off_next = {7'b0, y_reg + 9'd1} * {8'b0, RB};
                        end
                    end
                    else
                    begin
                        col_next  = col_reg + 3'd1;
                        bits_next = {bits_reg[6:0], 1'b0};
                        x_next    = x_reg + 11'd1;
                    end
                end
            end
            S_FLUSH:
            begin
                if (free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            row_reg   <= 3'd0;
            col_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        bits_reg    <= bits_next;
        x_reg       <= x_next;
        xb_reg      <= xb_next;
        y_reg       <= y_next;
        row_off_reg <= row_off_next;
        code_reg    <= code_next;
        code_ok_reg <= code_ok_next;
    end

    // one glyph bit per step, MSB leads
    assign ctl.step  = (state_reg == S_SCAN) && free;
    assign ctl.emit  = bits_reg[7] || cfg.fill_background;
    assign ctl.flush = (state_reg == S_FLUSH) && free;

    assign pix.pixel_x     = x_reg;
    assign pix.pixel_y     = y_reg;
    assign pix.pixel_color = bits_reg[7] ? cfg.fg_color : cfg.bg_color;
    assign pix.byte_offset = row_off_reg + {8'b0, x_reg[10:3]};
    assign pix.bit_mask    = 8'h80 >> x_reg[2:0];

endmodule

// File: rtl/gpe_out.sv
module gpe_out (
    input  logic          clk,
    input  logic          rst_n,
    input  gpe_pkg::ctl_t ctl,
    input  gpe_pkg::pix_t pix,
    output logic          free,
    gpe_pix_if.source     out_ch
);

    logic          pend_valid_reg;
    gpe_pkg::pix_t pend_reg;
    logic          out_valid_reg;
    gpe_pkg::pix_t out_reg;
    logic          out_last_reg;
    logic          load_out;

    assign free     = !out_valid_reg || out_ch.ready;
    // a pixel leaves the hold stage once a later one exists or the glyph ends
    assign load_out = pend_valid_reg && ((ctl.step && ctl.emit) || ctl.flush);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.step && ctl.emit)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (ctl.flush)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (ctl.step && ctl.emit)
        begin
            pend_reg <= pix;
        end
        if (load_out)
        begin
            out_reg      <= pend_reg;
            out_last_reg <= ctl.flush;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.pixel_x     = out_reg.pixel_x;
    assign out_ch.pixel_y     = out_reg.pixel_y;
    assign out_ch.pixel_color = out_reg.pixel_color;
    assign out_ch.byte_offset = out_reg.byte_offset;
    assign out_ch.bit_mask    = out_reg.bit_mask;
    assign out_ch.last_pixel  = out_last_reg;

endmodule

// File: rtl/glyph_pixel_expander_top.sv
// Channel   Dir  Beat                                               Flow
// in_ch     in   action, char_code, char_pos, font_row, font_byte   valid/ready
// out_ch    out  pixel_x, pixel_y, pixel_color, byte_offset,        valid/ready
//                bit_mask, last_pixel
// cfg       in   cfg_we, cfg_index, cfg_data                        write only
//
// A font store beat writes its row into the font RAM. A render beat walks accept,
// a font read wait, 64 glyph bits one per cycle while not stalled, and one flush.
// The next font row is prefetched from the font RAM during the current row.
// One pixel is held back so the final one can carry last_pixel.
// Reset clears control and loads the register defaults; the font RAM is not cleared.
// Output stalls freeze the bit walk; in_ch is ready only between characters.
module glyph_pixel_expander_top #(
    parameter int FONT_CHARS = 256,
    parameter int ROW_BYTES  = 80
) (
    input  logic       clk,
    input  logic       rst_n,
    gpe_in_if.sink     in_ch,
    gpe_pix_if.source  out_ch,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [9:0] cfg_data
);

    gpe_pkg::cfg_t cfg_reg;
    gpe_pkg::ctl_t ctl;
    gpe_pkg::pix_t pix;
    logic          free;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fg_color        <= gpe_pkg::FG_COLOR_RST;
            cfg_reg.bg_color        <= gpe_pkg::BG_COLOR_RST;
            cfg_reg.fill_background <= gpe_pkg::FILL_BG_RST;
            cfg_reg.origin_x        <= gpe_pkg::ORIGIN_X_RST;
            cfg_reg.origin_y        <= gpe_pkg::ORIGIN_Y_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gpe_pkg::REG_FG_COLOR: cfg_reg.fg_color        <= cfg_data[3:0];
                gpe_pkg::REG_BG_COLOR: cfg_reg.bg_color        <= cfg_data[3:0];
                gpe_pkg::REG_FILL_BG:  cfg_reg.fill_background <= cfg_data[0];
                gpe_pkg::REG_ORIGIN_X: cfg_reg.origin_x        <= cfg_data;
                gpe_pkg::REG_ORIGIN_Y: cfg_reg.origin_y        <= cfg_data[8:0];
                default:
                begin
                end
            endcase
        end
    end

    gpe_seq #(
        .FONT_CHARS (FONT_CHARS),
        .ROW_BYTES  (ROW_BYTES)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .cfg   (cfg_reg),
        .free  (free),
        .ctl   (ctl),
        .pix   (pix)
    );

    gpe_out u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .pix    (pix),
        .free   (free),
        .out_ch (out_ch)
    );

endmodule

// File: rtl/gpe_checker.sv
module gpe_checker #(
    parameter int ROW_BYTES = 80
) (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [10:0] pixel_x,
    input logic [8:0]  pixel_y,
    input logic [3:0]  pixel_color,
    input logic [15:0] byte_offset,
    input logic [7:0]  bit_mask,
    input logic        last_pixel
);

    localparam logic [7:0] RB = 8'(ROW_BYTES);

    // a stalled beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
            && $stable(pixel_color) && $stable(last_pixel))
        else $error("stalled pixel beat changed");

    // mask matches the column within the byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> bit_mask == (8'h80 >> pixel_x[2:0]))
        else $error("bit_mask does not match pixel_x");

    // planar offset follows from the coordinates
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> byte_offset == ({7'b0, pixel_y} * {8'b0, RB}) + {8'b0, pixel_x[10:3]})
        else $error("byte_offset does not match coordinates");

    // a character is still in progress until its last pixel is shown
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_pixel |-> !in_ready)
        else $error("input ready in the middle of a character");

endmodule

bind glyph_pixel_expander_top gpe_checker #(
    .ROW_BYTES (ROW_BYTES)
) u_gpe_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .pixel_x     (out_ch.pixel_x),
    .pixel_y     (out_ch.pixel_y),
    .pixel_color (out_ch.pixel_color),
    .byte_offset (out_ch.byte_offset),
    .bit_mask    (out_ch.bit_mask),
    .last_pixel  (out_ch.last_pixel)
);

// File: bench/glyph_render_checker.sv
`timescale 1ns / 100ps

module glyph_render_checker #(
    parameter int FONT_CHARS = 256,
    parameter int ROW_BYTES  = 80
) (
    input  logic       clk,
    input  logic       rst_n,
    gpe_in_if          in_ch,
    gpe_pix_if         out_ch,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [9:0] cfg_data,
    output int         mismatches,
    output int         outstanding
);

    typedef struct packed {
        gpe_pkg::pix_t pix;
        logic          last;
    } pixel_write_t;

    gpe_pkg::cfg_t settings;
    logic [7:0]    font_rom [FONT_CHARS*8];
    pixel_write_t  pending_pixels [$];
    int            mismatch_count = 0;

    // expand one character through the font at the current settings
    function automatic void expand_glyph(input logic [7:0] code, input logic [6:0] pos);
        pixel_write_t glyph_px [$];
        pixel_write_t w;
        logic [7:0]   line;
        logic [10:0]  px;
        logic [8:0]   py;
        for (int r = 0; r < 8; r++)
        begin
            // codes past the font render blank
            line = (int'(code) < FONT_CHARS) ? font_rom[int'(code)*8 + r] : 8'h00;
            for (int c = 0; c < 8; c++)
            begin
                if (line[7-c] || settings.fill_background)
                begin
                    px = 11'(settings.origin_x) + 11'(pos) * 11'd8 + 11'(c);
                    py = settings.origin_y + 9'(r);
                    w.pix.pixel_x     = px;
                    w.pix.pixel_y     = py;
                    w.pix.pixel_color = line[7-c] ? settings.fg_color : settings.bg_color;
                    w.pix.byte_offset = 16'(ROW_BYTES * int'(py) + int'(px >> 3));
                    w.pix.bit_mask    = 8'h80 >> px[2:0];
                    w.last            = 1'b0;
                    glyph_px.push_back(w);
                end
            end
        end
        if (glyph_px.size() > 0)
            glyph_px[glyph_px.size()-1].last = 1'b1;
        foreach (glyph_px[i])
            pending_pixels.push_back(glyph_px[i]);
    endfunction

    function automatic void check_field(input string name, input int expected, input int actual);
        if (expected != actual)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d, got %0d", $time, name, expected, actual);
        end
    endfunction

    // watch both channels and the config port
    always @(posedge clk or negedge rst_n)
    begin
        pixel_write_t exp_px;
        if (!rst_n)
        begin
            settings = '{fg_color: gpe_pkg::FG_COLOR_RST, bg_color: gpe_pkg::BG_COLOR_RST,
                         fill_background: gpe_pkg::FILL_BG_RST,
                         origin_x: gpe_pkg::ORIGIN_X_RST,
                         origin_y: gpe_pkg::ORIGIN_Y_RST};
            pending_pixels.delete();
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_pixels.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: expected no pixel beat, got x=%0d y=%0d color=%0d",
                             $time, out_ch.pixel_x, out_ch.pixel_y, out_ch.pixel_color);
                end
                else
                begin
                    exp_px = pending_pixels.pop_front();
                    check_field("pixel_x", exp_px.pix.pixel_x, out_ch.pixel_x);
                    check_field("pixel_y", exp_px.pix.pixel_y, out_ch.pixel_y);
                    check_field("pixel_color", exp_px.pix.pixel_color, out_ch.pixel_color);
                    check_field("byte_offset", exp_px.pix.byte_offset, out_ch.byte_offset);
                    check_field("bit_mask", exp_px.pix.bit_mask, out_ch.bit_mask);
                    check_field("last_pixel", exp_px.last, out_ch.last_pixel);
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                if (in_ch.action == gpe_pkg::ACT_STORE)
                begin
                    if (int'(in_ch.char_code) < FONT_CHARS)
                        font_rom[int'(in_ch.char_code)*8 + int'(in_ch.font_row)] =
                            in_ch.font_byte;
                end
                else
                begin
                    expand_glyph(in_ch.char_code, in_ch.char_pos);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    gpe_pkg::REG_FG_COLOR: settings.fg_color        = cfg_data[3:0];
                    gpe_pkg::REG_BG_COLOR: settings.bg_color        = cfg_data[3:0];
                    gpe_pkg::REG_FILL_BG:  settings.fill_background = cfg_data[0];
                    gpe_pkg::REG_ORIGIN_X: settings.origin_x        = cfg_data[9:0];
                    gpe_pkg::REG_ORIGIN_Y: settings.origin_y        = cfg_data[8:0];
                    default: ;
                endcase
            end
        end
        mismatches  <= mismatch_count;
        outstanding <= pending_pixels.size();
    end

endmodule

// File: bench/tb_glyph_pixel_expander_top.sv
`timescale 1ns / 100ps

module tb_glyph_pixel_expander_top;

    localparam int FONT_CHARS      = 256;
    localparam int ROW_BYTES       = 80;
    localparam int ITEMS_PER_PHASE = 80;
    // a blank render keeps the block busy with no output
    localparam int SETTLE_CYCLES   = 100;
    localparam int STALL_LIMIT     = 2000;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic [9:0] cfg_data;
    logic       sink_ready = 1'b0;
    int         send_idle_pct = 25;
    int         recv_idle_pct = 60;
    int         mismatches;
    int         outstanding;
    int         stall_cycles = 0;
    int         items_sent = 0;
    logic [7:0] rows_written [FONT_CHARS];
    logic [7:0] complete_glyphs [$];

    gpe_in_if  in_ch ();
    gpe_pix_if out_ch ();

    assign out_ch.ready = sink_ready;

    glyph_pixel_expander_top #(
        .FONT_CHARS (FONT_CHARS),
        .ROW_BYTES  (ROW_BYTES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    glyph_render_checker #(
        .FONT_CHARS (FONT_CHARS),
        .ROW_BYTES  (ROW_BYTES)
    ) pixel_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // random backpressure on the pixel side
    always @(posedge clk)
        sink_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);

    // cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("tb_glyph_pixel_expander_top: FAIL");
        $finish;
    end

    function automatic logic [7:0] glyph_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80 >> $urandom_range(7);
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [6:0] random_pos();
        case ($urandom_range(9))
            0:       return 7'd0;
            1:       return 7'd127;
            default: return 7'($urandom_range(127));
        endcase
    endfunction

    task automatic send_beat(input logic action, input logic [7:0] code,
                             input logic [6:0] pos, input logic [2:0] row,
                             input logic [7:0] bits);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_ch.valid     <= 1'b1;
        in_ch.action    <= action;
        in_ch.char_code <= code;
        in_ch.char_pos  <= pos;
        in_ch.font_row  <= row;
        in_ch.font_byte <= bits;
        do @(posedge clk); while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic store_font_row(input logic [7:0] code, input logic [2:0] row,
                                  input logic [7:0] bits);
        logic was_complete;
        send_beat(gpe_pkg::ACT_STORE, code, 7'($urandom_range(127)), row, bits);
        was_complete = (rows_written[code] == 8'hFF);
        rows_written[code][row] = 1'b1;
        if (!was_complete && rows_written[code] == 8'hFF)
            complete_glyphs.push_back(code);
    endtask

    task automatic store_glyph(input logic [7:0] code);
        for (int r = 0; r < 8; r++)
            store_font_row(code, 3'(r), glyph_byte());
    endtask

    task automatic render_char(input logic [7:0] code, input logic [6:0] pos);
        send_beat(gpe_pkg::ACT_RENDER, code, pos, 3'($urandom_range(7)),
                  8'($urandom_range(255)));
    endtask

    // hold input off until every pixel is out and the block has gone quiet
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [9:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic write_settings(input logic [3:0] fg, input logic [3:0] bg,
                                  input logic fill, input logic [9:0] ox,
                                  input logic [8:0] oy);
        write_reg(gpe_pkg::REG_FG_COLOR, 10'(fg));
        write_reg(gpe_pkg::REG_BG_COLOR, 10'(bg));
        write_reg(gpe_pkg::REG_FILL_BG, 10'(fill));
        write_reg(gpe_pkg::REG_ORIGIN_X, ox);
        write_reg(gpe_pkg::REG_ORIGIN_Y, 10'(oy));
        cfg_we <= 1'b0;
    endtask

    // mostly complete glyph loads followed by renders, some stray row writes
    task automatic run_random_phase(input int n_items);
        int         stop_at;
        int         pick;
        logic [7:0] code;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 45 || complete_glyphs.size() == 0)
            begin
                code = 8'($urandom_range(255));
                store_glyph(code);
                repeat ($urandom_range(1, 3)) render_char(code, random_pos());
            end
            else if (pick < 85)
            begin
                render_char(complete_glyphs[$urandom_range(complete_glyphs.size() - 1)],
                            random_pos());
            end
            else
            begin
                store_font_row(8'($urandom_range(255)), 3'($urandom_range(7)), glyph_byte());
            end
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.action    <= gpe_pkg::ACT_STORE;
        in_ch.char_code <= 8'd0;
        in_ch.char_pos  <= 7'd0;
        in_ch.font_row  <= 3'd0;
        in_ch.font_byte <= 8'd0;
        cfg_we          <= 1'b0;
        cfg_index       <= gpe_pkg::REG_FG_COLOR;
        cfg_data        <= 10'd0;
        foreach (rows_written[i])
            rows_written[i] = 8'h00;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: solid glyph at reset settings
        for (int r = 0; r < 8; r++)
            store_font_row(8'd255, 3'(r), 8'hFF);
        render_char(8'd255, 7'd0);
        // blank glyph in transparent mode gives no pixels
        for (int r = 0; r < 8; r++)
            store_font_row(8'd0, 3'(r), 8'h00);
        render_char(8'd0, 7'd127);
        // only the edge columns of one row
        store_font_row(8'd0, 3'd3, 8'h81);
        render_char(8'd0, 7'd79);
        // fill mode at the far origin: y wraps, x runs past the screen
        wait_drained();
        write_settings(4'd0, 4'd15, 1'b1, 10'd1023, 9'd511);
        render_char(8'd0, 7'd127);
        render_char(8'd255, 7'd0);

        for (int phase = 0; phase < 6; phase++)
        begin
            wait_drained();
            send_idle_pct <= (phase < 2) ? 25 : (phase < 4) ? 60 : 0;
            recv_idle_pct <= (phase < 2) ? 60 : (phase < 4) ? 25 : 0;
            case (phase)
                0: write_settings(4'($urandom_range(15)), 4'($urandom_range(15)), 1'b0,
                                  10'd0, 9'd0);
                1: write_settings(4'd15, 4'd0, 1'b1, 10'd639, 9'd479);
                2: write_settings(4'($urandom_range(15)), 4'($urandom_range(15)), 1'b1,
                                  10'($urandom_range(1023)), 9'($urandom_range(511)));
                3: write_settings(4'd0, 4'd15, 1'b0, 10'd1023, 9'd511);
                4: write_settings(4'($urandom_range(15)), 4'($urandom_range(15)), 1'b1,
                                  10'd20, 9'd20);
                default: write_settings(4'($urandom_range(15)), 4'($urandom_range(15)),
                                        1'b0, 10'($urandom_range(1023)),
                                        9'($urandom_range(511)));
            endcase
            run_random_phase(ITEMS_PER_PHASE);
        end

        wait_drained();
        if (mismatches == 0 && outstanding == 0)
            $display("tb_glyph_pixel_expander_top: PASS");
        else
            $display("tb_glyph_pixel_expander_top: FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/gpe_pkg.sv
rtl/gpe_in_if.sv
rtl/gpe_pix_if.sv
rtl/gpe_ram.sv
rtl/gpe_seq.sv
rtl/gpe_out.sv
rtl/glyph_pixel_expander_top.sv
rtl/gpe_checker.sv
bench/glyph_render_checker.sv
bench/tb_glyph_pixel_expander_top.sv
